>>> rtl/touch_contact_slot_tracker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the touch contact slot tracker
// Concurrent checks sampled on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TOUCH_CONTACT_SLOT_TRACKER_DEFINES_SVH
`define TOUCH_CONTACT_SLOT_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tcst_pkg.sv
// ----------------------------------------------------------------------------
// tcst_pkg
// Types and codes shared by the touch contact slot tracker and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package tcst_pkg;

    typedef enum logic {
        OP_REPORT    = 1'b0,
        OP_FRAME_END = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        EV_UP   = 2'd0,
        EV_DOWN = 2'd1,
        EV_MOVE = 2'd2
    } t_event_kind;

    typedef enum logic [1:0] {
        CFG_ENABLE = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_index;

    localparam int POS_W  = 14;
    localparam int NORM_W = 16;
    localparam int ID_W   = 16;
    localparam int PROD_W = NORM_W + POS_W;

    localparam logic [POS_W-1:0] WIDTH_RESET  = 14'd1024;
    localparam logic [POS_W-1:0] HEIGHT_RESET = 14'd768;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [POS_W-1:0] t_cfg_data;
    typedef logic [3:0]       t_slot_idx;

    typedef struct packed {
        t_op              operation;
        logic [ID_W-1:0]   contact_id;
        logic [NORM_W-1:0] norm_x;
        logic [NORM_W-1:0] norm_y;
    } t_item;

    typedef struct packed {
        t_event_kind event_kind;
        t_slot_idx   slot_index;
        t_pos        pos_x;
        t_pos        pos_y;
        logic        last_event;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0] contact;
        t_pos            x;
        t_pos            y;
    } t_slot_entry;

endpackage

`default_nettype wire

>>> rtl/tcst_ram.sv
// ----------------------------------------------------------------------------
// tcst_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output      logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/touch_contact_slot_tracker.sv
// ----------------------------------------------------------------------------
// touch_contact_slot_tracker
// Multitouch contact slot table with per-frame pointer up, down and move events.
// ----------------------------------------------------------------------------
// A transaction is taken at the rising edge at which start is high and busy is
// low. A contact report searches the slot RAM one entry per cycle and keeps
// busy high until it reaches the matching slot or, for a new contact, the
// first slot past those in use, so a report against a full table searches
// every slot. A frame end reads one slot per cycle and keeps busy high until
// it has read every slot in use. Its events leave one per cycle on
// o_result_valid, each registered from the read of its slot and the last in
// the first cycle with busy low. They must be taken as they come since the
// receiver cannot stall. Items taken while the block is disabled, and a frame
// end on an empty table, leave busy low.
// The slot RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_contact_slot_tracker_defines.svh"

module touch_contact_slot_tracker #(
    parameter int SLOTS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output      logic                 busy,
    input  wire tcst_pkg::t_item      i_item,
    output      logic                 o_result_valid,
    output      tcst_pkg::t_result    o_result,
    input  wire logic                 i_cfg_we,
    input  wire tcst_pkg::t_cfg_index i_cfg_index,
    input  wire tcst_pkg::t_cfg_data  i_cfg_data
);

    localparam int IDXW = $clog2(SLOTS);
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam logic [CNTW-1:0] SLOTS_CNT = CNTW'(SLOTS);
    localparam logic [CNTW-1:0] ONE_CNT   = CNTW'(1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_EMIT   = 3'b100
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_enable;
    tcst_pkg::t_pos                 r_width;
    tcst_pkg::t_pos                 r_height;
    logic [tcst_pkg::ID_W-1:0]      r_id;
    logic [tcst_pkg::PROD_W-1:0]    r_prod_x;
    logic [tcst_pkg::PROD_W-1:0]    r_prod_y;
    logic [CNTW-1:0]                r_idx, n_idx;
    logic [CNTW-1:0]                r_used, n_used;
    logic [CNTW-1:0]                r_top, n_top;
    logic [SLOTS-1:0]               r_act, n_act;
    logic [SLOTS-1:0]               r_was, n_was;
    logic                           r_out_valid, n_out_valid;
    tcst_pkg::t_result              r_out, n_out;

    tcst_pkg::t_slot_entry          w_rd_data;
    tcst_pkg::t_slot_entry          w_wr_data;
    logic [IDXW-1:0]                w_raddr;
    logic [IDXW-1:0]                w_waddr;
    logic [IDXW-1:0]                w_idx;
    logic                           w_we;
    logic                           w_in_range;
    logic                           w_hit;
    logic                           w_full;
    logic                           w_last;
    logic                           w_accept;
    logic [SLOTS-1:0]               w_used_mask;

    assign busy           = (r_state != ST_IDLE);
    assign w_accept       = start && !busy;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    assign w_idx      = r_idx[IDXW-1:0];
    assign w_in_range = (r_idx < r_used);
    assign w_hit      = w_in_range && (w_rd_data.contact == r_id);
    assign w_full     = (r_used == SLOTS_CNT);
    assign w_last     = (r_idx == r_used - ONE_CNT);

    assign w_we    = (r_state == ST_SEARCH) && (w_hit || (!w_in_range && !w_full));
    assign w_waddr = w_hit ? w_idx : r_used[IDXW-1:0];
    assign w_raddr = (r_state == ST_IDLE) ? '0 : IDXW'(r_idx + ONE_CNT);

    assign w_wr_data.contact = r_id;
    assign w_wr_data.x       = r_prod_x[tcst_pkg::PROD_W-1:tcst_pkg::NORM_W];
    assign w_wr_data.y       = r_height - r_prod_y[tcst_pkg::PROD_W-1:tcst_pkg::NORM_W];

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_used_mask[i] = (CNTW'(i) < r_used);
        end
    end

    tcst_ram #(
        .WIDTH ($bits(tcst_pkg::t_slot_entry)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr_data),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_used      = r_used;
        n_top       = r_top;
        n_act       = r_act;
        n_was       = r_was;
        n_out_valid = 1'b0;
        n_out       = r_out;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && r_enable) begin
                    n_idx = '0;
                    n_top = '0;
                    if (i_item.operation == tcst_pkg::OP_REPORT) begin
                        n_state = ST_SEARCH;
                    end else if (r_used != '0) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SEARCH: begin
                if (w_hit) begin
                    n_act[w_idx] = 1'b1;
                    n_state      = ST_IDLE;
                end else if (!w_in_range) begin
                    if (!w_full) begin
                        n_act[w_waddr] = 1'b1;
                        n_was[w_waddr] = 1'b0;
                        n_used         = r_used + ONE_CNT;
                    end
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + ONE_CNT;
                end
            end
            ST_EMIT: begin
                n_out_valid = 1'b1;
                if (!r_act[w_idx] && r_was[w_idx]) begin
                    n_out.event_kind = tcst_pkg::EV_UP;
                end else if (r_act[w_idx] && !r_was[w_idx]) begin
                    n_out.event_kind = tcst_pkg::EV_DOWN;
                end else begin
                    n_out.event_kind = tcst_pkg::EV_MOVE;
                end
                n_out.slot_index = tcst_pkg::t_slot_idx'(r_idx);
                n_out.pos_x      = w_rd_data.x;
                n_out.pos_y      = w_rd_data.y;
                n_out.last_event = w_last;
                if (r_act[w_idx]) begin
                    n_top = r_idx + ONE_CNT;
                end
                n_idx = r_idx + ONE_CNT;
                if (w_last) begin
                    n_used = n_top;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (CNTW'(i) < n_top) begin
                            n_was[i] = r_act[i];
                            n_act[i] = 1'b0;
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_enable    <= 1'b0;
            r_width     <= tcst_pkg::WIDTH_RESET;
            r_height    <= tcst_pkg::HEIGHT_RESET;
            r_idx       <= '0;
            r_used      <= '0;
            r_top       <= '0;
            r_act       <= '0;
            r_was       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_used      <= n_used;
            r_top       <= n_top;
            r_act       <= n_act;
            r_was       <= n_was;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tcst_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                    tcst_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    tcst_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_id     <= i_item.contact_id;
            r_prod_x <= {{tcst_pkg::POS_W{1'b0}}, i_item.norm_x}
                      * {{tcst_pkg::NORM_W{1'b0}}, r_width};
            r_prod_y <= {{tcst_pkg::POS_W{1'b0}}, i_item.norm_y}
                      * {{tcst_pkg::NORM_W{1'b0}}, r_height};
        end
    end

    `TCST_ASSERT_SAME(a_used_bound, 1'b1, r_used <= SLOTS_CNT, "Slot count exceeds table size.")
    `TCST_ASSERT_SAME(a_no_active_above_used, 1'b1, (r_act & ~w_used_mask) == '0,
                      "Active flag set on a slot that is not in use.")
    `TCST_ASSERT_NEXT(a_event_from_emit, r_state != ST_EMIT, !r_out_valid,
                      "Event issued without a frame-end read.")
    `TCST_ASSERT_SAME(a_last_ends_emit, r_out_valid && r_out.last_event, r_state == ST_IDLE,
                      "Frame end still emitting after its last event.")

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for touch_contact_slot_tracker
// Drives contact reports and frame ends through the start/busy handshake and
// checks each pointer event against the bench's slot table model or the event
// given in a directed row. A short directed table comes first, then random
// phases under changing window sizes, with bursts of idle cycles at the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcst_pkg::*;

    localparam int SLOT_COUNT    = 16;
    localparam int ITEM_TARGET   = 430;
    localparam int CALM_TAIL     = 50;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 1000;

    typedef struct {
        bit         is_cfg;
        t_cfg_index cfg_idx;
        t_cfg_data  cfg_val;
        t_item      item;
        int         n_typed;
        t_result    typed;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_item      i_item;
    logic       o_result_valid;
    t_result    o_result;
    logic       i_cfg_we;
    t_cfg_index i_cfg_index;
    t_cfg_data  i_cfg_data;

    logic                 cfg_enabled;
    t_pos                 cfg_width;
    t_pos                 cfg_height;
    logic [ID_W-1:0]      slot_id     [SLOT_COUNT];
    logic                 slot_act    [SLOT_COUNT];
    logic                 slot_was    [SLOT_COUNT];
    t_pos                 slot_x      [SLOT_COUNT];
    t_pos                 slot_y      [SLOT_COUNT];
    int                   slots_in_use;

    t_result         frame_events   [$];
    t_result         pending_events [$];
    t_stim_row       stim_table     [$];
    logic [ID_W-1:0] id_pool        [$];
    t_result         next_event;

    int mismatches   = 0;
    int items_done   = 0;
    int stall_cycles = 0;
    bit idling_on    = 1'b1;

    touch_contact_slot_tracker #(
        .SLOTS(SLOT_COUNT)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Slot table model: updates its own table and fills frame_events.
    function automatic void track_item(t_item it);
        int              j;
        int              k;
        logic [29:0]     prod_x;
        logic [29:0]     prod_y;
        t_result         ev;
        frame_events.delete();
        if (!cfg_enabled) begin
            return;
        end
        if (it.operation == OP_REPORT) begin
            j = 0;
            while (j < slots_in_use && slot_id[j] != it.contact_id) begin
                j++;
            end
            if (j == slots_in_use) begin
                if (slots_in_use >= SLOT_COUNT) begin
                    return;
                end
                slots_in_use++;
                slot_id[j]  = it.contact_id;
                slot_was[j] = 1'b0;
            end
            slot_act[j] = 1'b1;
            prod_x = {14'd0, it.norm_x} * {16'd0, cfg_width};
            prod_y = {14'd0, it.norm_y} * {16'd0, cfg_height};
            slot_x[j] = prod_x[29:16];
            slot_y[j] = cfg_height - prod_y[29:16];
        end else begin
            for (k = 0; k < slots_in_use; k++) begin
                if (!slot_act[k] && slot_was[k]) begin
                    ev.event_kind = EV_UP;
                end else if (slot_act[k] && !slot_was[k]) begin
                    ev.event_kind = EV_DOWN;
                end else begin
                    ev.event_kind = EV_MOVE;
                end
                ev.slot_index = t_slot_idx'(k);
                ev.pos_x      = slot_x[k];
                ev.pos_y      = slot_y[k];
                ev.last_event = (k + 1 == slots_in_use);
                frame_events.push_back(ev);
            end
            while (slots_in_use > 0 && !slot_act[slots_in_use-1]) begin
                slots_in_use--;
            end
            for (k = 0; k < slots_in_use; k++) begin
                slot_was[k] = slot_act[k];
                slot_act[k] = 1'b0;
            end
        end
    endfunction

    function automatic void add_cfg(t_cfg_index idx, t_cfg_data val);
        t_stim_row r;
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        r.item    = '0;
        r.n_typed = -1;
        r.typed   = '0;
        stim_table.push_back(r);
    endfunction

    function automatic void add_item(t_op op, logic [ID_W-1:0] id,
                                     logic [NORM_W-1:0] nx, logic [NORM_W-1:0] ny);
        t_stim_row r;
        r.is_cfg            = 1'b0;
        r.cfg_idx           = CFG_ENABLE;
        r.cfg_val           = '0;
        r.item.operation    = op;
        r.item.contact_id   = id;
        r.item.norm_x       = nx;
        r.item.norm_y       = ny;
        r.n_typed           = -1;
        r.typed             = '0;
        stim_table.push_back(r);
    endfunction

    function automatic void add_frame_check(int n, t_event_kind kind, t_slot_idx s,
                                            t_pos x, t_pos y, logic last);
        t_stim_row r;
        r.is_cfg            = 1'b0;
        r.cfg_idx           = CFG_ENABLE;
        r.cfg_val           = '0;
        r.item.operation    = OP_FRAME_END;
        r.item.contact_id   = 16'hC3A5;
        r.item.norm_x       = 16'h5A3C;
        r.item.norm_y       = 16'hA5C3;
        r.n_typed           = n;
        r.typed.event_kind  = kind;
        r.typed.slot_index  = s;
        r.typed.pos_x       = x;
        r.typed.pos_y       = y;
        r.typed.last_event  = last;
        stim_table.push_back(r);
    endfunction

    function automatic logic [NORM_W-1:0] pick_norm();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return NORM_W'($urandom);
        endcase
    endfunction

    function automatic t_cfg_data pick_size();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return WIDTH_RESET;
            default: return t_cfg_data'($urandom_range(16383));
        endcase
    endfunction

    task automatic pause_sender();
        if (idling_on && items_done < ITEM_TARGET - CALM_TAIL && $urandom_range(3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    // Called at a falling edge; returns at a falling edge with the block idle
    // and the register written.
    task automatic write_reg(t_cfg_index idx, t_cfg_data val);
        start = 1'b0;
        while (pending_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        case (idx)
            CFG_ENABLE: cfg_enabled = val[0];
            CFG_WIDTH:  cfg_width   = val;
            CFG_HEIGHT: cfg_height  = val;
            default:    ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_item(t_item it, int n_typed, t_result typed);
        start  = 1'b1;
        i_item = it;
        do begin
            @(posedge i_clk);
        end while (busy);
        items_done++;
        track_item(it);
        if (n_typed < 0) begin
            foreach (frame_events[k]) begin
                pending_events.push_back(frame_events[k]);
            end
        end else if (n_typed > 0) begin
            pending_events.push_back(typed);
        end
        @(negedge i_clk);
    endtask

    task automatic send_random(t_op op, logic [ID_W-1:0] id);
        t_item it;
        it.operation  = op;
        it.contact_id = id;
        it.norm_x     = pick_norm();
        it.norm_y     = pick_norm();
        pause_sender();
        send_item(it, -1, '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: kind %0d slot %0d", o_result.event_kind,
                       o_result.slot_index);
                mismatches++;
            end else begin
                next_event = pending_events.pop_front();
                if (o_result.event_kind !== next_event.event_kind) begin
                    $error("event_kind: expected %0d, actual %0d",
                           next_event.event_kind, o_result.event_kind);
                    mismatches++;
                end
                if (o_result.slot_index !== next_event.slot_index) begin
                    $error("slot_index: expected %0d, actual %0d",
                           next_event.slot_index, o_result.slot_index);
                    mismatches++;
                end
                if (o_result.pos_x !== next_event.pos_x) begin
                    $error("pos_x: expected %0d, actual %0d",
                           next_event.pos_x, o_result.pos_x);
                    mismatches++;
                end
                if (o_result.pos_y !== next_event.pos_y) begin
                    $error("pos_y: expected %0d, actual %0d",
                           next_event.pos_y, o_result.pos_y);
                    mismatches++;
                end
                if (o_result.last_event !== next_event.last_event) begin
                    $error("last_event: expected %0d, actual %0d",
                           next_event.last_event, o_result.last_event);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int        pool_n;
        int        n_rep;
        t_cfg_data en_word;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_ENABLE;
        i_cfg_data  = '0;

        cfg_enabled  = 1'b0;
        cfg_width    = WIDTH_RESET;
        cfg_height   = HEIGHT_RESET;
        slots_in_use = 0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            slot_act[k] = 1'b0;
            slot_was[k] = 1'b0;
        end

        // Disabled block ignores reports and frame ends; then the basic up/down/move cycle.
        add_item(OP_REPORT, 16'h1234, 16'h4000, 16'h4000);
        add_frame_check(0, EV_UP, 4'd0, '0, '0, 1'b0);
        add_cfg(CFG_ENABLE, 14'd1);
        add_frame_check(0, EV_UP, 4'd0, '0, '0, 1'b0);
        add_item(OP_REPORT, 16'h0000, 16'h0000, 16'h0000);
        add_frame_check(1, EV_DOWN, 4'd0, 14'd0, 14'd768, 1'b1);
        add_frame_check(1, EV_UP, 4'd0, 14'd0, 14'd768, 1'b1);
        add_item(OP_REPORT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_item(OP_REPORT, 16'hFFFF, 16'h8000, 16'h8000);
        add_frame_check(1, EV_DOWN, 4'd0, 14'd512, 14'd384, 1'b1);
        add_item(OP_REPORT, 16'hFFFF, 16'hFFFF, 16'h0000);
        add_frame_check(1, EV_MOVE, 4'd0, 14'd1023, 14'd768, 1'b1);
        // A second contact leaves slot 0 idle below the top of the table.
        add_item(OP_REPORT, 16'h0001, 16'h1111, 16'h2222);
        add_item(OP_FRAME_END, 16'h0000, 16'h0000, 16'h0000);
        add_item(OP_REPORT, 16'h0001, 16'h3333, 16'h4444);
        add_item(OP_FRAME_END, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_item(OP_FRAME_END, 16'h0000, 16'h0000, 16'h0000);
        add_cfg(CFG_WIDTH, 14'd16383);
        add_cfg(CFG_HEIGHT, 14'd16383);
        add_item(OP_REPORT, 16'hABCD, 16'hFFFF, 16'h0000);
        add_frame_check(1, EV_DOWN, 4'd0, 14'd16382, 14'd16383, 1'b1);
        add_cfg(CFG_WIDTH, 14'd0);
        add_cfg(CFG_HEIGHT, 14'd0);
        add_item(OP_REPORT, 16'h5555, 16'hFFFF, 16'hFFFF);
        add_item(OP_FRAME_END, 16'h0000, 16'h0000, 16'h0000);
        add_cfg(CFG_ENABLE, 14'h3FFE);
        add_item(OP_REPORT, 16'h0002, 16'h1234, 16'h1234);
        add_frame_check(0, EV_UP, 4'd0, '0, '0, 1'b0);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_table[r]) begin
            if (stim_table[r].is_cfg) begin
                write_reg(stim_table[r].cfg_idx, stim_table[r].cfg_val);
            end else begin
                pause_sender();
                send_item(stim_table[r].item, stim_table[r].n_typed, stim_table[r].typed);
            end
        end

        while (items_done < ITEM_TARGET) begin
            idling_on = ($urandom_range(3) != 0);
            en_word    = t_cfg_data'($urandom);
            en_word[0] = ($urandom_range(7) != 0);
            write_reg(CFG_ENABLE, en_word);
            write_reg(CFG_WIDTH, pick_size());
            write_reg(CFG_HEIGHT, pick_size());
            // A pool larger than the table makes new contacts hit a full table.
            id_pool.delete();
            pool_n = $urandom_range(3, 24);
            repeat (pool_n) id_pool.push_back(ID_W'($urandom));
            if ($urandom_range(1)) begin
                id_pool.push_back('0);
                id_pool.push_back('1);
            end
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(4) == 0) begin
                    n_rep = $urandom_range(12, 24);
                end else begin
                    n_rep = $urandom_range(0, 8);
                end
                repeat (n_rep) begin
                    if ($urandom_range(9) == 0) begin
                        send_random(t_op'($urandom_range(1)), ID_W'($urandom));
                    end else begin
                        send_random(OP_REPORT, id_pool[$urandom_range(id_pool.size() - 1)]);
                    end
                end
                send_random(OP_FRAME_END, ID_W'($urandom));
            end
        end

        start = 1'b0;
        while (pending_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/tcst_pkg.sv
rtl/tcst_ram.sv
rtl/touch_contact_slot_tracker.sv
sim/tb.sv
